### sv/clws_pkg.sv
package clws_pkg;

    // command codes carried in the input tuser field
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_INIT   = 3'd1;
    localparam logic [2:0] FUNC_CHAR   = 3'd2;
    localparam logic [2:0] FUNC_CURSOR = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
    localparam logic [1:0] CFG_COMMAND_WAIT = 2'd1;
    localparam logic [1:0] CFG_POWER_UP     = 2'd2;
    localparam logic [1:0] CFG_CLEAR_WAIT   = 2'd3;

    localparam int unsigned CFG_WIDTH = 24;

    localparam logic [CFG_WIDTH-1:0] RST_ENABLE_PULSE = 24'd1;
    localparam logic [CFG_WIDTH-1:0] RST_COMMAND_WAIT = 24'd40;
    localparam logic [CFG_WIDTH-1:0] RST_POWER_UP     = 24'd100000;
    localparam logic [CFG_WIDTH-1:0] RST_CLEAR_WAIT   = 24'd2000;

    // instruction bytes
    localparam logic [7:0] BYTE_FUNCTION_SET = 8'b0011_1100;
    localparam logic [7:0] BYTE_DISPLAY_ON   = 8'b0000_1100;
    localparam logic [7:0] BYTE_CLEAR        = 8'b0000_0001;
    localparam logic [7:0] BYTE_ENTRY_MODE   = 8'b0000_0110;
    localparam logic [7:0] BYTE_SET_DDRAM    = 8'h80;
    localparam logic [7:0] COLUMN_MAX        = 8'h0F;

    // init sequence has this many bytes
    localparam logic [2:0] INIT_LEN = 3'd5;

    // byte sent at each step of the init sequence
    function automatic logic [7:0] init_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = BYTE_FUNCTION_SET;
            3'd1:    b = BYTE_FUNCTION_SET;
            3'd2:    b = BYTE_DISPLAY_ON;
            3'd3:    b = BYTE_CLEAR;
            3'd4:    b = BYTE_ENTRY_MODE;
            default: b = BYTE_ENTRY_MODE;
        endcase
        return b;
    endfunction

endpackage

### sv/char_lcd_write_sequencer.sv
// Write sequencer for a character LCD on an 8-bit parallel bus (RS, E, D7..D0).
// Each input transaction is either a time tick (tuser 0) or a command: init (1),
// write character (2), set cursor (3) or clear (4). Only ticks advance time;
// a command is refused (accepted 0) while a sequence or wait is running, so the
// user polls busy and sends ticks until it drops. Every input transaction gives
// exactly one output transaction with the pin levels after it was handled.
// An item passes through an input register and combinational next-state logic
// into the output register, so one transaction per clock is sustained; only
// output backpressure stalls the input side. The user must write the timing
// registers through the cfg port only while idle; the block does not enforce it.
module char_lcd_write_sequencer
    import clws_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // char_code[7:0], line_number[15:8], column[23:16]
    input  logic [2:0]           s_axis_tuser,  // func[2:0]
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata   // rs_pin[0], enable_pin[1], data_bus[9:2],
                                                // busy_res[10], accepted[11], zero[15:12]
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POWER,
        PH_ENABLE,
        PH_CMDWAIT,
        PH_CLEARWAIT
    } t_phase;

    // timing registers
    logic [CFG_WIDTH-1:0] r_cfg_enable;
    logic [CFG_WIDTH-1:0] r_cfg_cmd;
    logic [CFG_WIDTH-1:0] r_cfg_power;
    logic [CFG_WIDTH-1:0] r_cfg_clear;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_in_func;
    logic [7:0]  r_in_char;
    logic [7:0]  r_in_line;
    logic [7:0]  r_in_col;

    // sequencer state
    t_phase                 r_phase,     n_phase;
    logic [TIMER_WIDTH-1:0] r_timer,     n_timer;
    logic [2:0]             r_init_step, n_init_step;
    logic                   r_in_init,   n_in_init;
    logic                   r_rs,        n_rs;
    logic                   r_en,        n_en;
    logic [7:0]             r_bus,       n_bus;
    logic                   n_taken;

    // output register
    logic        r_out_valid;
    logic [11:0] r_out_data;

    logic advance;

    // timer loads, cut or zero-extended to the timer width
    logic [31:0]            ext_enable, ext_cmd, ext_power, ext_clear;
    logic [TIMER_WIDTH-1:0] ld_enable, ld_cmd, ld_power, ld_clear;

    assign ext_enable = {{(32 - CFG_WIDTH){1'b0}}, r_cfg_enable};
    assign ext_cmd    = {{(32 - CFG_WIDTH){1'b0}}, r_cfg_cmd};
    assign ext_power  = {{(32 - CFG_WIDTH){1'b0}}, r_cfg_power};
    assign ext_clear  = {{(32 - CFG_WIDTH){1'b0}}, r_cfg_clear};
    assign ld_enable  = ext_enable[TIMER_WIDTH-1:0];
    assign ld_cmd     = ext_cmd[TIMER_WIDTH-1:0];
    assign ld_power   = ext_power[TIMER_WIDTH-1:0];
    assign ld_clear   = ext_clear[TIMER_WIDTH-1:0];

    // handshake: the input register moves on when the output register is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable <= RST_ENABLE_PULSE;
            r_cfg_cmd    <= RST_COMMAND_WAIT;
            r_cfg_power  <= RST_POWER_UP;
            r_cfg_clear  <= RST_CLEAR_WAIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE_PULSE: r_cfg_enable <= i_cfg_data;
                CFG_COMMAND_WAIT: r_cfg_cmd    <= i_cfg_data;
                CFG_POWER_UP:     r_cfg_power  <= i_cfg_data;
                CFG_CLEAR_WAIT:   r_cfg_clear  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= s_axis_tuser;
            r_in_char <= s_axis_tdata[7:0];
            r_in_line <= s_axis_tdata[15:8];
            r_in_col  <= s_axis_tdata[23:16];
        end
    end

    // next state for the held transaction
    always_comb begin
        logic [2:0] next_step;
        logic [7:0] cursor_col;
        next_step   = r_init_step + 3'd1;
        cursor_col  = (r_in_col > COLUMN_MAX) ? COLUMN_MAX : r_in_col;
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_init_step = r_init_step;
        n_in_init   = r_in_init;
        n_rs        = r_rs;
        n_en        = r_en;
        n_bus       = r_bus;
        n_taken     = 1'b0;
        if (r_in_func == FUNC_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (r_timer > TIMER_WIDTH'(1)) begin
                    n_timer = r_timer - TIMER_WIDTH'(1);
                end else begin
                    case (r_phase)
                        PH_POWER: begin
                            n_init_step = '0;
                            n_rs        = 1'b0;
                            n_bus       = init_byte(3'd0);
                            n_en        = 1'b1;
                            n_phase     = PH_ENABLE;
                            n_timer     = ld_enable;
                        end
                        PH_ENABLE: begin
                            n_en    = 1'b0;
                            n_phase = PH_CMDWAIT;
                            n_timer = ld_cmd;
                        end
                        PH_CMDWAIT, PH_CLEARWAIT: begin
                            if (r_phase == PH_CMDWAIT && !r_rs && r_bus == BYTE_CLEAR) begin
                                n_phase = PH_CLEARWAIT;
                                n_timer = ld_clear;
                            end else if (r_in_init && next_step < INIT_LEN) begin
                                // next byte of the init sequence
                                n_init_step = next_step;
                                n_rs        = 1'b0;
                                n_bus       = init_byte(next_step);
                                n_en        = 1'b1;
                                n_phase     = PH_ENABLE;
                                n_timer     = ld_enable;
                            end else begin
                                n_in_init   = 1'b0;
                                n_init_step = '0;
                                n_phase     = PH_IDLE;
                                n_timer     = '0;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_timer = '0;
                        end
                    endcase
                end
            end
        end else if (r_phase == PH_IDLE) begin
            case (r_in_func)
                FUNC_INIT: begin
                    n_taken     = 1'b1;
                    n_in_init   = 1'b1;
                    n_init_step = '0;
                    n_phase     = PH_POWER;
                    n_timer     = ld_power;
                end
                FUNC_CHAR: begin
                    n_taken = 1'b1;
                    n_rs    = 1'b1;
                    n_bus   = r_in_char;
                    n_en    = 1'b1;
                    n_phase = PH_ENABLE;
                    n_timer = ld_enable;
                end
                FUNC_CURSOR: begin
                    n_taken = 1'b1;
                    n_rs    = 1'b0;
                    n_bus   = BYTE_SET_DDRAM | {1'b0, r_in_line[0], 6'b0} | cursor_col;
                    n_en    = 1'b1;
                    n_phase = PH_ENABLE;
                    n_timer = ld_enable;
                end
                FUNC_CLEAR: begin
                    n_taken = 1'b1;
                    n_rs    = 1'b0;
                    n_bus   = BYTE_CLEAR;
                    n_en    = 1'b1;
                    n_phase = PH_ENABLE;
                    n_timer = ld_enable;
                end
                default: ;
            endcase
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_init_step <= '0;
            r_in_init   <= 1'b0;
            r_rs        <= 1'b0;
            r_en        <= 1'b0;
            r_bus       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase     <= n_phase;
                r_timer     <= n_timer;
                r_init_step <= n_init_step;
                r_in_init   <= n_in_init;
                r_rs        <= n_rs;
                r_en        <= n_en;
                r_bus       <= n_bus;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out_data <= {n_taken, (n_phase != PH_IDLE), n_bus, n_en, n_rs};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_data};

endmodule

### test/char_lcd_write_sequencer_test.sv
module char_lcd_write_sequencer_test
    import clws_pkg::*;
();

    localparam int CYCLE_LIMIT = 500_000;
    localparam logic [CFG_WIDTH-1:0] TIMING_MAX = '1;

    // bytes of the power-on sequence, first byte in the low bits
    localparam logic [39:0] POWER_ON_BYTES = {BYTE_ENTRY_MODE, BYTE_CLEAR, BYTE_DISPLAY_ON,
                                              BYTE_FUNCTION_SET, BYTE_FUNCTION_SET};

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_POWER,
        SEQ_ENABLE,
        SEQ_CMDWAIT,
        SEQ_CLEARWAIT
    } t_seq_phase;

    // pin levels of one output transaction, packed as in m_axis_tdata
    typedef struct packed {
        logic       accepted;
        logic       busy;
        logic [7:0] data_bus;
        logic       enable_pin;
        logic       rs_pin;
    } t_pins;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_index = '0;
    logic [CFG_WIDTH-1:0] i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;  // char_code[7:0], line_number[15:8], column[23:16]
    logic [2:0]           s_axis_tuser = '0;  // func[2:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;       // rs_pin[0], enable_pin[1], data_bus[9:2],
                                              // busy_res[10], accepted[11], zero[15:12]

    // timing registers as the block should hold them
    logic [CFG_WIDTH-1:0] pulse_len;
    logic [CFG_WIDTH-1:0] cmd_wait;
    logic [CFG_WIDTH-1:0] power_wait;
    logic [CFG_WIDTH-1:0] clear_wait;

    // sequencer state as the block should hold it
    t_seq_phase           seq_phase;
    logic [CFG_WIDTH-1:0] tick_left;
    logic [2:0]           init_idx;
    logic                 in_init;
    logic                 rs_q;
    logic                 en_q;
    logic [7:0]           bus_q;

    t_pins pin_expect_q[$];
    int    fault_count = 0;
    int    cycle_count = 0;
    bit    tx_no_idle = 1'b0;
    bit    rx_no_stall = 1'b0;

    char_lcd_write_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void lcd_reset_state();
        pulse_len  = RST_ENABLE_PULSE;
        cmd_wait   = RST_COMMAND_WAIT;
        power_wait = RST_POWER_UP;
        clear_wait = RST_CLEAR_WAIT;
        seq_phase  = SEQ_IDLE;
        tick_left  = '0;
        init_idx   = '0;
        in_init    = 1'b0;
        rs_q       = 1'b0;
        en_q       = 1'b0;
        bus_q      = '0;
    endfunction

    // put a byte on the bus and raise the enable line
    function automatic void begin_byte(logic rs, logic [7:0] b);
        rs_q      = rs;
        bus_q     = b;
        en_q      = 1'b1;
        seq_phase = SEQ_ENABLE;
        tick_left = pulse_len;
    endfunction

    // a byte and its waits are over: next power-on byte or back to idle
    function automatic void finish_byte();
        logic more;
        more = 1'b0;
        if (in_init) begin
            init_idx = init_idx + 3'd1;
            if (init_idx < INIT_LEN) begin
                more = 1'b1;
                begin_byte(1'b0, POWER_ON_BYTES[init_idx*8 +: 8]);
            end else begin
                in_init  = 1'b0;
                init_idx = '0;
            end
        end
        if (!more) begin
            seq_phase = SEQ_IDLE;
            tick_left = '0;
        end
    endfunction

    function automatic void wait_elapsed();
        case (seq_phase)
            SEQ_POWER: begin
                init_idx = '0;
                begin_byte(1'b0, POWER_ON_BYTES[7:0]);
            end
            SEQ_ENABLE: begin
                en_q      = 1'b0;
                seq_phase = SEQ_CMDWAIT;
                tick_left = cmd_wait;
            end
            SEQ_CMDWAIT: begin
                // an instruction byte equal to clear needs the long wait
                if (!rs_q && bus_q == BYTE_CLEAR) begin
                    seq_phase = SEQ_CLEARWAIT;
                    tick_left = clear_wait;
                end else begin
                    finish_byte();
                end
            end
            SEQ_CLEARWAIT: finish_byte();
            default: begin
                seq_phase = SEQ_IDLE;
                tick_left = '0;
            end
        endcase
    endfunction

    // apply one input transaction and return the pin levels it should give
    function automatic t_pins lcd_step(logic [2:0] func, logic [7:0] ch, logic [7:0] ln,
                                       logic [7:0] col);
        t_pins      p;
        logic       taken;
        logic [7:0] c;
        taken = 1'b0;
        if (func == FUNC_TICK) begin
            if (seq_phase != SEQ_IDLE) begin
                if (tick_left > 1)
                    tick_left = tick_left - 1'b1;
                else
                    wait_elapsed();
            end
        end else if (func <= FUNC_CLEAR && seq_phase == SEQ_IDLE) begin
            taken = 1'b1;
            case (func)
                FUNC_INIT: begin
                    in_init   = 1'b1;
                    init_idx  = '0;
                    seq_phase = SEQ_POWER;
                    tick_left = power_wait;
                end
                FUNC_CHAR: begin_byte(1'b1, ch);
                FUNC_CURSOR: begin
                    c = (col > COLUMN_MAX) ? COLUMN_MAX : col;
                    begin_byte(1'b0, BYTE_SET_DDRAM | {1'b0, ln[0], 6'b0} | c);
                end
                default: begin_byte(1'b0, BYTE_CLEAR);
            endcase
        end
        p.rs_pin     = rs_q;
        p.enable_pin = en_q;
        p.data_bus   = bus_q;
        p.busy       = (seq_phase != SEQ_IDLE);
        p.accepted   = taken;
        return p;
    endfunction

    initial lcd_reset_state();

    // ---------------------------------------------------------------- drivers

    task automatic send_item(logic [2:0] func, logic [7:0] ch, logic [7:0] ln,
                             logic [7:0] col);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {col, ln, ch};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        pin_expect_q.push_back(lcd_step(func, ch, ln, col));
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_random(logic [2:0] func);
        send_item(func, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic tick_until_idle();
        while (seq_phase != SEQ_IDLE) send_tick();
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_put(logic [1:0] idx, logic [CFG_WIDTH-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ENABLE_PULSE: pulse_len  = val;
            CFG_COMMAND_WAIT: cmd_wait   = val;
            CFG_POWER_UP:     power_wait = val;
            default:          clear_wait = val;
        endcase
    endtask

    // write all timing registers once the block has gone quiet
    task automatic set_timing(logic [CFG_WIDTH-1:0] ep, logic [CFG_WIDTH-1:0] cw,
                              logic [CFG_WIDTH-1:0] pu, logic [CFG_WIDTH-1:0] cl);
        wait_results_drained();
        cfg_put(CFG_ENABLE_PULSE, ep);
        cfg_put(CFG_COMMAND_WAIT, cw);
        cfg_put(CFG_POWER_UP, pu);
        cfg_put(CFG_CLEAR_WAIT, cl);
        i_cfg_we <= 1'b0;
    endtask

    // output side stalls a random number of cycles before each transaction
    initial begin : rx_ready
        int stall;
        wait (i_rst_n);
        forever begin
            stall = rx_no_stall ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin : check_results
        t_pins want;
        t_pins got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_pins'(m_axis_tdata[11:0]);
            if (pin_expect_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected output transaction %h", m_axis_tdata);
            end else begin
                want = pin_expect_q.pop_front();
                if (got.rs_pin != want.rs_pin || got.enable_pin != want.enable_pin
                        || got.data_bus != want.data_bus || got.busy != want.busy
                        || got.accepted != want.accepted || m_axis_tdata[15:12] != '0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $write("mismatch (exp/got): rs %0b/%0b en %0b/%0b bus %02h/%02h ",
                               want.rs_pin, got.rs_pin, want.enable_pin, got.enable_pin,
                               want.data_bus, got.data_bus);
                        $display("busy %0b/%0b acc %0b/%0b pad 0/%h", want.busy, got.busy,
                                 want.accepted, got.accepted, m_axis_tdata[15:12]);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset timing: one pulse tick then the 40 tick command wait
    task automatic test_reset_values();
        send_tick();
        send_item(FUNC_CHAR, 8'h41, 8'h00, 8'h00);
        send_item(FUNC_CURSOR, 8'h00, 8'h01, 8'h05);
        tick_until_idle();
    endtask

    task automatic test_init_sequence();
        set_timing(24'd1, 24'd1, 24'd1, 24'd1);
        send_item(FUNC_INIT, 8'h00, 8'h00, 8'h00);
        repeat (5) send_tick();
        send_item(FUNC_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        tick_until_idle();
        set_timing(24'd3, 24'd2, 24'd5, 24'd4);
        send_item(FUNC_INIT, 8'hFF, 8'hFF, 8'hFF);
        tick_until_idle();
    endtask

    task automatic test_commands();
        logic [7:0] lines [4];
        logic [7:0] cols [4];
        lines = '{8'h00, 8'h01, 8'hFF, 8'hFE};
        cols  = '{8'h00, 8'h0F, 8'h10, 8'hFF};
        set_timing(24'd2, 24'd3, 24'd2, 24'd3);
        send_item(FUNC_CHAR, 8'h00, 8'hFF, 8'hFF);
        tick_until_idle();
        send_item(FUNC_CHAR, 8'hFF, 8'h00, 8'h00);
        tick_until_idle();
        foreach (lines[i]) begin
            send_item(FUNC_CURSOR, 8'h55, lines[i], cols[i]);
            tick_until_idle();
        end
        send_item(FUNC_CLEAR, 8'h00, 8'h00, 8'h00);
        // unused codes, once busy and once idle
        for (int f = int'(FUNC_CLEAR) + 1; f < 8; f++) send_random(3'(f));
        tick_until_idle();
        for (int f = int'(FUNC_CLEAR) + 1; f < 8; f++) send_random(3'(f));
    endtask

    // a wait loaded with zero lasts a single tick
    task automatic test_zero_waits();
        set_timing('0, '0, '0, '0);
        send_item(FUNC_INIT, 8'h00, 8'h00, 8'h00);
        tick_until_idle();
        send_item(FUNC_CHAR, 8'h7E, 8'h00, 8'h00);
        tick_until_idle();
        send_item(FUNC_CLEAR, 8'h00, 8'h00, 8'h00);
        tick_until_idle();
    endtask

    function automatic logic [2:0] pick_command();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0)
            return FUNC_INIT;
        else if (r <= 5)
            return FUNC_CHAR;
        else if (r <= 9)
            return FUNC_CURSOR;
        return FUNC_CLEAR;
    endfunction

    // mostly polled command flows with random content, some noise and refusals
    task automatic test_random_traffic();
        int scale;
        int r;
        for (int p = 0; p < 6; p++) begin
            scale = (p == 5) ? 4 : 1;
            if (p == 0)
                set_timing(24'd1, 24'd1, 24'd1, 24'd1);
            else
                set_timing(24'($urandom_range(1, 4 * scale)), 24'($urandom_range(1, 6 * scale)),
                           24'($urandom_range(1, 16 * scale)),
                           24'($urandom_range(1, 10 * scale)));
            for (int n = 0; n < 280; n++) begin
                if (n % 70 == 0) begin
                    tx_no_idle  = ($urandom_range(0, 2) == 0);
                    rx_no_stall = ($urandom_range(0, 2) == 0);
                end
                r = $urandom_range(0, 19);
                if (seq_phase == SEQ_IDLE) begin
                    if (r < 16)
                        send_random(pick_command());
                    else if (r < 19)
                        send_tick();
                    else
                        send_random(3'($urandom_range(int'(FUNC_CLEAR) + 1, 7)));
                end else begin
                    if (r < 17)
                        send_tick();
                    else
                        send_random(3'($urandom_range(int'(FUNC_INIT), 7)));
                end
            end
            tick_until_idle();
        end
        tx_no_idle  = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    // largest register values: the block stays busy for the rest of the run
    task automatic test_max_timing();
        set_timing(TIMING_MAX, TIMING_MAX, TIMING_MAX, TIMING_MAX);
        send_tick();
        send_random(3'($urandom_range(int'(FUNC_CLEAR) + 1, 7)));
        send_item(FUNC_CLEAR, 8'h00, 8'h00, 8'h00);
        for (int n = 0; n < 30; n++) begin
            if (n % 10 == 5)
                send_random(pick_command());
            else
                send_tick();
        end
    endtask

    initial begin : run_tests
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_init_sequence();
        test_commands();
        test_zero_waits();
        test_random_traffic();
        test_max_timing();
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && pin_expect_q.size() == 0)
            $display("char_lcd_write_sequencer_test passed");
        else
            $display("char_lcd_write_sequencer_test failed");
        $finish;
    end

    // end the run if it hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("char_lcd_write_sequencer_test failed");
        $finish;
    end

endmodule
